// File: src/scd_pkg.sv
// Package: shared constants for the sector cache directory.
`default_nettype none
package scd_pkg;
  localparam int ENTRIES_DEF      = 64;
  localparam int SECTOR_BYTES_DEF = 512;
  localparam int SLOT_W           = 6;
  localparam int SECTOR_W         = 32;
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;
  localparam logic POLICY_CLOCK = 1'b0;
endpackage
`default_nettype wire

// File: src/sector_cache_directory_clock.sv
// Top level: fully associative sector cache directory with clock/FIFO replacement.
//
// Usage: pulse start with opcode, sector, byte_offset and byte_count while busy
// is low. Read and write requests produce exactly one result; a flush produces
// one result per dirty entry, in slot order, with last set on the final one,
// and nothing if no entry is dirty. Each result is shown for one cycle marked
// by strobe; the receiver cannot stall, results are never held.
// A lookup walks the tag memory one entry a cycle; a hit ends the walk at the
// matching slot. A miss fills an empty slot if there is one, else evicts by FIFO
// order or by the clock hand, which clears and passes over accessed entries first.
// A flush walks every entry and reports each dirty one. The tag memory read port
// sets the pace of both walks. Busy falls with the final strobe (or after the
// walk, if a flush finds nothing dirty); the next request may start in that cycle.
// The user writes policy through cfg_we/cfg_data (0 clock, 1 FIFO) while idle;
// the block itself does not enforce this.
// Reset clears valid, dirty and accessed bits, both pointers and policy; the
// tag memory is not cleared since tags are only read for valid entries.
`default_nettype none
module sector_cache_directory_clock #(
  parameter int ENTRIES      = scd_pkg::ENTRIES_DEF,
  parameter int SECTOR_BYTES = scd_pkg::SECTOR_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode,
  input  wire logic [scd_pkg::SECTOR_W-1:0]  sector,
  input  wire logic [8:0]                    byte_offset,
  input  wire logic [9:0]                    byte_count,
  output logic                               strobe,
  output logic                               kind,
  output logic                               hit,
  output logic [scd_pkg::SLOT_W-1:0]         slot,
  output logic                               evict_writeback,
  output logic [scd_pkg::SECTOR_W-1:0]       evicted_sector,
  output logic                               fetch,
  output logic [scd_pkg::SECTOR_W-1:0]       flush_sector,
  output logic                               last
);
  localparam int AW = $clog2(ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_LOOK = 3'd1, S_VICT = 3'd2,
                         S_FILL = 3'd3, S_FLSH = 3'd4, S_FOUT = 3'd5;

  logic [2:0]    state;
  logic          policy;
  logic [ENTRIES-1:0] vbits, dbits, abits;
  logic [AW-1:0] clk_ptr, fifo_ptr, idx, ridx, free_idx, pend_idx;
  logic          free_found, pend, pend_valid;
  logic          rvalid;
  logic          wr, full;
  logic [scd_pkg::SECTOR_W-1:0] sec_q;
  logic [scd_pkg::SECTOR_W-1:0] pend_sec;
  logic          tag_we;
  logic [AW-1:0] tag_waddr, tag_raddr;
  logic [scd_pkg::SECTOR_W-1:0] tag_rdata;
  logic [AW-1:0] vict;
  logic          look_done;

  scd_ram #(.WIDTH(scd_pkg::SECTOR_W), .DEPTH(ENTRIES)) u_tags (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(sec_q),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  assign tag_we    = (state == S_FILL);
  assign tag_waddr = vict;
  assign tag_raddr = (state == S_VICT) ? vict : idx;
  assign busy      = (state != S_IDLE);
  assign look_done = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; policy <= scd_pkg::POLICY_CLOCK;
      vbits <= '0; dbits <= '0; abits <= '0;
      clk_ptr <= '0; fifo_ptr <= '0; strobe <= 1'b0;
      rvalid <= 1'b0; pend_valid <= 1'b0; free_found <= 1'b0;
      idx <= '0; ridx <= '0; vict <= '0; pend <= 1'b0; pend_idx <= '0;
      free_idx <= '0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        policy <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start && (opcode == scd_pkg::OP_READ || opcode == scd_pkg::OP_WRITE)) begin
            sec_q <= sector; wr <= (opcode == scd_pkg::OP_WRITE);
            full <= (byte_offset == 9'd0) && (byte_count == 10'(SECTOR_BYTES));
            idx <= '0; rvalid <= 1'b0; free_found <= 1'b0; state <= S_LOOK;
          end else if (start && opcode == scd_pkg::OP_FLUSH) begin
            idx <= '0; rvalid <= 1'b0; pend <= 1'b0; state <= S_FLSH;
          end
        end
        S_LOOK: begin
          rvalid <= !(look_done && ridx == LAST_IDX); ridx <= idx;
          if (!look_done) idx <= idx + AW'(1);
          if (!free_found && !vbits[idx]) begin
            free_found <= 1'b1; free_idx <= idx;
          end
          if (rvalid && vbits[ridx] && tag_rdata == sec_q) begin
            abits[ridx] <= 1'b1;
            if (wr) dbits[ridx] <= 1'b1;
            strobe <= 1'b1; kind <= scd_pkg::KIND_ACCESS; hit <= 1'b1;
            slot <= scd_pkg::SLOT_W'(ridx); evict_writeback <= 1'b0;
            evicted_sector <= '0; fetch <= 1'b0; flush_sector <= '0; last <= 1'b1;
            state <= S_IDLE;
          end else if (!rvalid && ridx == LAST_IDX && idx == LAST_IDX) begin
            if (free_found) begin
              vict <= free_idx; state <= S_FILL;
            end else if (policy != scd_pkg::POLICY_CLOCK) begin
              vict <= fifo_ptr;
              fifo_ptr <= (fifo_ptr == LAST_IDX) ? '0 : fifo_ptr + AW'(1);
              state <= S_VICT;
            end else if (abits[clk_ptr]) begin
              abits[clk_ptr] <= 1'b0;
              clk_ptr <= (clk_ptr == LAST_IDX) ? '0 : clk_ptr + AW'(1);
            end else begin
              vict <= clk_ptr;
              clk_ptr <= (clk_ptr == LAST_IDX) ? '0 : clk_ptr + AW'(1);
              state <= S_VICT;
            end
          end
        end
        S_VICT: begin
          state <= S_FILL;
          pend_valid <= 1'b1;
        end
        S_FILL: begin
          strobe <= 1'b1; kind <= scd_pkg::KIND_ACCESS; hit <= 1'b0;
          slot <= scd_pkg::SLOT_W'(vict);
          evict_writeback <= pend_valid && dbits[vict];
          evicted_sector <= (pend_valid && dbits[vict]) ? tag_rdata : '0;
          fetch <= !(wr && full); flush_sector <= '0; last <= 1'b1;
          vbits[vict] <= 1'b1; abits[vict] <= 1'b1; dbits[vict] <= wr;
          pend_valid <= 1'b0; state <= S_IDLE;
        end
        S_FLSH: begin
          rvalid <= 1'b1; ridx <= idx;
          if (rvalid && vbits[ridx] && dbits[ridx]) begin
            if (pend) begin
              strobe <= 1'b1; kind <= scd_pkg::KIND_FLUSH; hit <= 1'b0;
              slot <= scd_pkg::SLOT_W'(pend_idx); evict_writeback <= 1'b0;
              evicted_sector <= '0; fetch <= 1'b0; flush_sector <= pend_sec;
              last <= 1'b0;
            end
            pend <= 1'b1; pend_idx <= ridx; pend_sec <= tag_rdata;
            dbits[ridx] <= 1'b0;
          end
          if (rvalid && ridx == LAST_IDX) begin
            state <= S_FOUT;
          end else if (!look_done) begin
            idx <= idx + AW'(1);
          end
        end
        S_FOUT: begin
          if (pend) begin
            strobe <= 1'b1; kind <= scd_pkg::KIND_FLUSH; hit <= 1'b0;
            slot <= scd_pkg::SLOT_W'(pend_idx); evict_writeback <= 1'b0;
            evicted_sector <= '0; fetch <= 1'b0; flush_sector <= pend_sec;
            last <= 1'b1;
          end
          pend <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == scd_pkg::KIND_ACCESS |-> !busy) else $error("access answer while busy");
  a_idle_start: assert property (@(posedge clk) disable iff (rst)
    !busy && start && opcode == scd_pkg::OP_READ |=> busy) else $error("read not taken");
  a_wb_sector: assert property (@(posedge clk) disable iff (rst)
    strobe && !evict_writeback |-> evicted_sector == '0) else $error("stray evicted sector");
  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |=> vbits[$past(vict)]) else $error("fill not valid");
`endif
endmodule
`default_nettype wire

// File: src/scd_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module scd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
